// ----- src/hbdec_pkg.sv -----
// ----------------------------------------------------------------------------
// hbdec_pkg - shared types and constants of the half-band I/Q decimator
// Depths, coefficient table builder and the MAC control word.
// ----------------------------------------------------------------------------
`default_nettype none

package hbdec_pkg;

  localparam int unsigned DEF_SAMPLE_BITS    = 24;
  localparam int unsigned DEF_COEF_FRAC_BITS = 24;

  localparam int unsigned ODD_DEPTH = 22;
  localparam int unsigned CEN_DEPTH = 11;
  localparam int unsigned PAIRS     = 11;
  localparam int unsigned TERMS     = PAIRS + 1;
  localparam int unsigned ODD_AW    = $clog2(ODD_DEPTH);
  localparam int unsigned CEN_AW    = $clog2(CEN_DEPTH);
  localparam int unsigned TERM_W    = $clog2(TERMS);
  localparam int unsigned COEF_SLOT = 32;

  localparam logic [63:0] DEC_SCALE = 64'd1000000000000000000;

  // odd-tap magnitudes, scaled by 1e18; signs alternate, first positive
  localparam logic [63:0] COEF_MAG [PAIRS] = '{
    64'd18566625444266,     64'd118469698701817,    64'd457318798253456,
    64'd1347840471412094,   64'd3321838571445455,   64'd7198422696929033,
    64'd14211106939802483,  64'd26424776824073383,  64'd48414810444971007,
    64'd96214669073304823,  64'd314881034738348550
  };

  typedef struct packed {
    logic clear;
    logic sum_en;
    logic mul_en;
    logic acc_en;
  } hbdec_mac_ctl_t;

  // quantized coefficients, one 32-bit slot each; last slot is the center tap
  function automatic logic [TERMS*COEF_SLOT-1:0] hbdec_coef_table(input int unsigned frac);
    logic [TERMS*COEF_SLOT-1:0] tbl;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] one;
    tbl = '0;
    one = 64'd1;
    for (int k = 0; k < PAIRS; k++) begin
      q = '0;
      r = COEF_MAG[k];
      for (int b = 0; b < frac; b++) begin
        r = {r[62:0], 1'b0};
        q = {q[62:0], 1'b0};
        if (r >= DEC_SCALE) begin
          r = r - DEC_SCALE;
          q = q | one;
        end
      end
      if ({r[62:0], 1'b0} >= DEC_SCALE) begin
        q = q + one;
      end
      if (k[0]) begin
        q = -q;
      end
      tbl[k*COEF_SLOT +: COEF_SLOT] = q[COEF_SLOT-1:0];
    end
    q = one << (frac - 1);
    tbl[PAIRS*COEF_SLOT +: COEF_SLOT] = q[COEF_SLOT-1:0];
    return tbl;
  endfunction

endpackage

`default_nettype wire

// ----- src/hbdec_mac.sv -----
// ----------------------------------------------------------------------------
// hbdec_mac - pre-add, multiply, accumulate lane with round and saturate
// Folds two taps, scales by a coefficient and sums into a wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdec_mac #(
  parameter int unsigned SAMPLE_BITS    = hbdec_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = hbdec_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire logic                                clk_i,
  input  wire hbdec_pkg::hbdec_mac_ctl_t           ctl_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       a_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       b_i,
  input  wire logic signed [COEF_FRAC_BITS:0]      coef_i,
  output logic        [SAMPLE_BITS-1:0]            res_o
);
  import hbdec_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CW    = COEF_FRAC_BITS + 1;
  localparam int unsigned ACC_W = SB + CW + 2;
  localparam int unsigned TOP   = COEF_FRAC_BITS + SB - 1;

  localparam logic signed [ACC_W-1:0] ROUND_INIT = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [SB:0]       sum_q;
  logic signed [CW-1:0]     coef_q;
  logic signed [SB+CW:0]    prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic        [ACC_W-1:TOP] hi_bits;

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_q  <= (SB+1)'(a_i) + (SB+1)'(b_i);
      coef_q <= coef_i;
    end
    if (ctl_i.mul_en) begin
      prod_q <= sum_q * coef_q;
    end
    if (ctl_i.clear) begin
      acc_q <= ROUND_INIT;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // floor shift of the pre-rounded sum, then clamp
  assign hi_bits = acc_q[ACC_W-1:TOP];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      res_o = acc_q[TOP:COEF_FRAC_BITS];
    end else if (acc_q[ACC_W-1]) begin
      res_o = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(SB-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ----- src/halfband_iq_decimate_by_two.sv -----
// ----------------------------------------------------------------------------
// halfband_iq_decimate_by_two - 45-tap half-band I/Q decimator by two
// One complex word in, one filtered word out for every second word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries input words {q, i}; m_axis carries filtered words {q, i}.
//   Input words alternate phase, starting even after reset. An even word is
//   stored in the center line and taken without starting a pass. An odd word is stored
//   in the 22-entry line and starts a filter pass: one MAC per component
//   steps through twelve terms (eleven folded pairs and the center tap),
//   one per cycle, with a three-stage read/pre-add/multiply pipeline.
//   s_axis_tready is low for the pass and returns in the same cycle as the
//   result is registered in the output register.
//   The result sits in an output register until m_axis_tready takes it; new
//   words are taken meanwhile, and a following pass holds at its end until
//   the register is free.
//   Reset clears the phase, the valid bits of both delay lines (empty
//   entries read as zero) and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module halfband_iq_decimate_by_two #(
  parameter int unsigned SAMPLE_BITS    = hbdec_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = hbdec_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  // in_i, in_q
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // out_i, out_q
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]             m_axis_tdata
);
  import hbdec_pkg::*;

  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned CW      = COEF_FRAC_BITS + 1;
  localparam int unsigned WORD_W  = 2 * SB;
  localparam int unsigned TDATA_W = ((WORD_W + 7) / 8) * 8;

  localparam logic [TERMS*COEF_SLOT-1:0] COEF_TBL = hbdec_coef_table(COEF_FRAC_BITS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(PAIRS);

  logic [1:0]             state_q, state_d;
  logic [TERM_W-1:0]      cnt_q, cnt_d;
  logic                   phase_q, phase_d;
  logic [ODD_AW-1:0]      wp_q, wp_d;
  logic [CEN_AW-1:0]      cwp_q, cwp_d;
  logic [ODD_DEPTH-1:0]   odd_vld_q, odd_vld_d;
  logic [CEN_DEPTH-1:0]   cen_vld_q, cen_vld_d;
  logic                   p1_q, p2_q, p3_q;
  logic                   out_vld_q, out_vld_d;
  logic [WORD_W-1:0]      out_word_q;

  logic [WORD_W-1:0]      odd_mem [ODD_DEPTH];
  logic [WORD_W-1:0]      cen_mem [CEN_DEPTH];
  logic [WORD_W-1:0]      rda_q, rdb_q, rdc_q;
  logic                   va_q, vb_q, vc_q;
  logic                   is_cen_q;
  logic [TERM_W-1:0]      cidx_q;

  logic                   in_acc, odd_we, cen_we, issue, pipe_empty, out_load;
  logic [WORD_W-1:0]      wdata;
  logic [ODD_AW:0]        a_sum, b_sum;
  logic [ODD_AW-1:0]      a_idx, b_idx;
  logic [WORD_W-1:0]      op_a, op_b;
  logic signed [CW-1:0]   coef;
  hbdec_mac_ctl_t         mac_ctl;
  logic [SB-1:0]          res_i, res_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign odd_we        = in_acc && phase_q;
  assign cen_we        = in_acc && !phase_q;
  assign wdata         = s_axis_tdata[WORD_W-1:0];
  assign issue         = (state_q == ST_RUN);
  assign pipe_empty    = !p1_q && !p2_q && !p3_q;
  assign out_load      = (state_q == ST_DRAIN) && pipe_empty && (!out_vld_q || m_axis_tready);

  // newest odd entry sits at wp-1; pair k reads wp-1-k and wp+k (mod depth)
  always_comb begin
    a_sum = {1'b0, wp_q} + (ODD_AW+1)'(ODD_DEPTH - 1) - (ODD_AW+1)'(cnt_q);
    b_sum = {1'b0, wp_q} + (ODD_AW+1)'(cnt_q);
    if (a_sum >= (ODD_AW+1)'(ODD_DEPTH)) begin
      a_sum = a_sum - (ODD_AW+1)'(ODD_DEPTH);
    end
    if (b_sum >= (ODD_AW+1)'(ODD_DEPTH)) begin
      b_sum = b_sum - (ODD_AW+1)'(ODD_DEPTH);
    end
    a_idx = a_sum[ODD_AW-1:0];
    b_idx = b_sum[ODD_AW-1:0];
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    wp_d      = wp_q;
    cwp_d     = cwp_q;
    odd_vld_d = odd_vld_q;
    cen_vld_d = cen_vld_q;
    out_vld_d = out_vld_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cen_we) begin
          phase_d          = 1'b1;
          cen_vld_d[cwp_q] = 1'b1;
          cwp_d = (cwp_q == CEN_AW'(CEN_DEPTH - 1)) ? '0 : cwp_q + 1'b1;
        end else if (odd_we) begin
          phase_d         = 1'b0;
          odd_vld_d[wp_q] = 1'b1;
          wp_d  = (wp_q == ODD_AW'(ODD_DEPTH - 1)) ? '0 : wp_q + 1'b1;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_TERM) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      phase_q   <= 1'b0;
      wp_q      <= '0;
      cwp_q     <= '0;
      odd_vld_q <= '0;
      cen_vld_q <= '0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      p3_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      wp_q      <= wp_d;
      cwp_q     <= cwp_d;
      odd_vld_q <= odd_vld_d;
      cen_vld_q <= cen_vld_d;
      p1_q      <= issue;
      p2_q      <= p1_q;
      p3_q      <= p2_q;
      out_vld_q <= out_vld_d;
    end
  end

  // delay line storage; the oldest center entry sits at the write pointer
  always_ff @(posedge clk_i) begin
    if (odd_we) begin
      odd_mem[wp_q] <= wdata;
    end
    if (cen_we) begin
      cen_mem[cwp_q] <= wdata;
    end
    rda_q    <= odd_mem[a_idx];
    rdb_q    <= odd_mem[b_idx];
    rdc_q    <= cen_mem[cwp_q];
    va_q     <= odd_vld_q[a_idx];
    vb_q     <= odd_vld_q[b_idx];
    vc_q     <= cen_vld_q[cwp_q];
    is_cen_q <= (cnt_q == LAST_TERM);
    cidx_q   <= cnt_q;
    if (out_load) begin
      out_word_q <= {res_q, res_i};
    end
  end

  always_comb begin
    if (is_cen_q) begin
      op_a = vc_q ? rdc_q : '0;
    end else begin
      op_a = va_q ? rda_q : '0;
    end
    op_b = (!is_cen_q && vb_q) ? rdb_q : '0;
  end

  assign coef = COEF_TBL[cidx_q*COEF_SLOT +: CW];

  assign mac_ctl.clear  = odd_we;
  assign mac_ctl.sum_en = p1_q;
  assign mac_ctl.mul_en = p2_q;
  assign mac_ctl.acc_en = p3_q;

  hbdec_mac #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac_i (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (op_a[SB-1:0]),
    .b_i   (op_b[SB-1:0]),
    .coef_i(coef),
    .res_o (res_i)
  );

  hbdec_mac #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac_q (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (op_a[WORD_W-1:SB]),
    .b_i   (op_b[WORD_W-1:SB]),
    .coef_i(coef),
    .res_o (res_q)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TDATA_W'(out_word_q);

  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= LAST_TERM))
    else $error("term counter past last term");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_q |-> (state_q != ST_IDLE))
    else $error("accumulate outside of a filter pass");

  a_odd_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    odd_we |=> ((state_q == ST_RUN) && (cnt_q == '0) && !phase_q))
    else $error("odd word did not start a pass");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!p1_q && !p2_q && !p3_q && !issue))
    else $error("result loaded with pipeline busy");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !s_axis_tready)
    else $error("input ready during a pass");

endmodule

`default_nettype wire

// ----- test/halfband_decim_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halfband_decim_checker - output predictor and scoreboard for the decimator
// Watches the input and output streams, runs a behavioral half-band
// decimator on every accepted input word and compares each output word,
// component by component, with the oldest expected word.
// ----------------------------------------------------------------------------
module halfband_decim_checker #(
  parameter int SW   = 24,
  parameter int FRAC = 24,
  parameter int DW   = ((2*SW+7)/8)*8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic [DW-1:0] in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  logic [DW-1:0] out_data_i,
  output int            fail_o,
  output int            pending_o,
  output int            results_o,
  output int            saturated_o
);

  localparam int ODD_N  = 22;
  localparam int CEN_N  = 11;
  localparam int PAIR_N = 11;
  localparam longint HALF = longint'(1) <<< (FRAC-1);
  localparam longint MAXV = (longint'(1) <<< (SW-1)) - 1;
  localparam longint MINV = -MAXV - 1;

  typedef struct packed {
    logic [SW-1:0] re;
    logic [SW-1:0] im;
  } iq_word_t;

  iq_word_t fir_q[$];
  longint   tap_coef[PAIR_N];
  longint   odd_line[2][ODD_N];
  longint   cen_line[2][CEN_N];
  bit       odd_phase;
  int       fails = 0;
  int       results = 0;
  int       sats = 0;

  // odd-tap magnitudes scaled by 1e18
  function automatic longint unsigned tap_mag(input int k);
    case (k)
      0:       return 64'd18566625444266;
      1:       return 64'd118469698701817;
      2:       return 64'd457318798253456;
      3:       return 64'd1347840471412094;
      4:       return 64'd3321838571445455;
      5:       return 64'd7198422696929033;
      6:       return 64'd14211106939802483;
      7:       return 64'd26424776824073383;
      8:       return 64'd48414810444971007;
      9:       return 64'd96214669073304823;
      default: return 64'd314881034738348550;
    endcase
  endfunction

  // round half away from zero: floor((floor(2x) + 1) / 2)
  function automatic longint quant_tap(input int k);
    logic [127:0] wide;
    longint       mag;
    wide = {64'd0, tap_mag(k)} << (FRAC+1);
    wide = wide / 128'd1000000000000000000;
    wide = (wide + 128'd1) >> 1;
    mag  = longint'(wide[62:0]);
    return k[0] ? -mag : mag;
  endfunction

  initial begin
    for (int k = 0; k < PAIR_N; k++) tap_coef[k] = quant_tap(k);
  end

  task automatic fir_eval(input int c, output logic [SW-1:0] y, output bit clip);
    longint acc;
    longint r;
    acc = cen_line[c][CEN_N-1] * HALF;
    for (int k = 0; k < PAIR_N; k++)
      acc += (odd_line[c][k] + odd_line[c][ODD_N-1-k]) * tap_coef[k];
    r    = (acc + HALF) >>> FRAC;
    clip = 1'b0;
    if (r > MAXV) begin
      r    = MAXV;
      clip = 1'b1;
    end else if (r < MINV) begin
      r    = MINV;
      clip = 1'b1;
    end
    y = r[SW-1:0];
  endtask

  task automatic take_word(input logic [SW-1:0] wi, input logic [SW-1:0] wq);
    longint   smp[2];
    iq_word_t exp_w;
    bit       clip_i;
    bit       clip_q;
    smp[0] = longint'($signed(wi));
    smp[1] = longint'($signed(wq));
    if (!odd_phase) begin
      for (int c = 0; c < 2; c++) begin
        for (int k = CEN_N-1; k > 0; k--) cen_line[c][k] = cen_line[c][k-1];
        cen_line[c][0] = smp[c];
      end
    end else begin
      for (int c = 0; c < 2; c++) begin
        for (int k = ODD_N-1; k > 0; k--) odd_line[c][k] = odd_line[c][k-1];
        odd_line[c][0] = smp[c];
      end
      fir_eval(0, exp_w.re, clip_i);
      fir_eval(1, exp_w.im, clip_q);
      if (clip_i || clip_q) sats++;
      fir_q.push_back(exp_w);
    end
    odd_phase = !odd_phase;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    iq_word_t want;
    if (!rst_ni) begin
      odd_phase = 1'b0;
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < ODD_N; k++) odd_line[c][k] = 0;
        for (int k = 0; k < CEN_N; k++) cen_line[c][k] = 0;
      end
      fir_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (fir_q.size() == 0) begin
          $error("output word with nothing expected: out_i %0d out_q %0d",
                 $signed(out_data_i[SW-1:0]), $signed(out_data_i[2*SW-1:SW]));
          fails++;
        end else begin
          want = fir_q.pop_front();
          results++;
          if (out_data_i[SW-1:0] !== want.re) begin
            $error("out_i mismatch: expected %0d, actual %0d",
                   $signed(want.re), $signed(out_data_i[SW-1:0]));
            fails++;
          end
          if (out_data_i[2*SW-1:SW] !== want.im) begin
            $error("out_q mismatch: expected %0d, actual %0d",
                   $signed(want.im), $signed(out_data_i[2*SW-1:SW]));
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        take_word(in_data_i[SW-1:0], in_data_i[2*SW-1:SW]);
    end
    fail_o      <= fails;
    pending_o   <= fir_q.size();
    results_o   <= results;
    saturated_o <= sats;
  end

endmodule

// ----- test/halfband_iq_decimate_by_two_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halfband_iq_decimate_by_two_tb - stream testbench for the I/Q decimator
// Drives directed extremes, then random runs of noise, small signals,
// constant extremes and sign-matched full-scale runs that push the filter
// into saturation, with random idling on both streams and one long output
// hold-off. The checker instance predicts and scores every output word.
// ----------------------------------------------------------------------------
module halfband_iq_decimate_by_two_tb;

  localparam int SW        = 24;
  localparam int DW        = ((2*SW+7)/8)*8;
  localparam int NUM_WORDS = 750;
  localparam int LIMIT     = 200000;
  localparam int TAIL      = 40;
  localparam int HOLD_AT   = 2000;
  localparam int HOLD_LEN  = 400;
  localparam int BUSY_AT   = 4500;
  localparam int BUSY_LEN  = 1200;
  localparam int CALM_FROM = 500;
  localparam int CALM_TO   = 620;
  localparam logic [SW-1:0] POS_FS = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] NEG_FS = {1'b1, {(SW-1){1'b0}}};

  logic          clk_i    = 1'b0;
  logic          rst_ni   = 1'b0;
  logic          s_tvalid = 1'b0;
  logic [DW-1:0] s_tdata  = '0;
  logic          m_tready = 1'b0;
  wire           s_tready;
  wire           m_tvalid;
  wire  [DW-1:0] m_tdata;

  int fail_n;
  int pend_n;
  int res_n;
  int sat_n;
  int words_sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  halfband_iq_decimate_by_two dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  halfband_decim_checker #(.SW(SW)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .fail_o      (fail_n),
    .pending_o   (pend_n),
    .results_o   (res_n),
    .saturated_o (sat_n)
  );

  task automatic send_word(input logic [SW-1:0] wi, input logic [SW-1:0] wq);
    bit calm;
    calm = (words_sent >= CALM_FROM) && (words_sent < CALM_TO);
    while (!calm && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {wq, wi};
    do @(posedge clk_i); while (!s_tready);
    words_sent++;
  endtask

  function automatic logic [SW-1:0] near_full(input bit neg);
    logic [SW-1:0] mag;
    mag = POS_FS - SW'($urandom_range(2047));
    return neg ? ~mag : mag;
  endfunction

  // sign of each odd word follows the tap it lands on at the final output
  task automatic saturating_run;
    bit neg_i;
    bit neg_q;
    int k;
    bit flip;
    neg_i = 1'($urandom_range(1));
    neg_q = 1'($urandom_range(1));
    for (int j = 0; j < 22; j++) begin
      send_word(near_full(neg_i), near_full(neg_q));
      k    = 21 - j;
      flip = (k < 11) ? k[0] : !k[0];
      send_word(near_full(neg_i ^ flip), near_full(neg_q ^ flip));
    end
  endtask

  task automatic random_burst;
    int sel;
    int len;
    sel = $urandom_range(99);
    if (sel < 40) begin
      if (words_sent % 2) send_word(SW'($urandom()), SW'($urandom()));
      saturating_run();
    end else begin
      len = $urandom_range(2, 24);
      for (int n = 0; n < len; n++) begin
        if (sel < 70)
          send_word(SW'($urandom()), SW'($urandom()));
        else if (sel < 85)
          send_word(SW'($signed($urandom_range(511)) - 256),
                    SW'($signed($urandom_range(511)) - 256));
        else
          send_word($urandom_range(1) ? POS_FS : NEG_FS,
                    $urandom_range(1) ? POS_FS : NEG_FS);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word('0, '0);
    send_word('0, '0);
    send_word(POS_FS, NEG_FS);
    send_word(NEG_FS, POS_FS);
    send_word(POS_FS, POS_FS);
    send_word(NEG_FS, NEG_FS);
    send_word(SW'(1), '1);
    send_word('1, SW'(1));
    send_word({(SW/2){2'b01}}, {(SW/2){2'b10}});
    send_word({(SW/2){2'b10}}, {(SW/2){2'b01}});
    for (int n = 0; n < 8; n++)
      send_word(n[1] ? NEG_FS : POS_FS, n[1] ? POS_FS : NEG_FS);
    for (int n = 0; n < 6; n++)
      send_word(n[0] ? POS_FS : NEG_FS, n[0] ? NEG_FS : POS_FS);

    while (words_sent < NUM_WORDS) random_burst();
    s_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pend_n != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("Sent %0d input words; %0d filtered words checked, %0d of them clipped.",
             words_sent, res_n, sat_n);
    $display("Covered full-scale and small signals, saturation, idling and a long hold-off.");
    if (fail_n == 0 && pend_n == 0) begin
      $display("halfband_iq_decimate_by_two verification clean");
    end else begin
      $display("halfband_iq_decimate_by_two verification failed");
    end
    $finish;
  end

  // output side: random stalls, one long hold-off, one stretch always ready
  initial begin
    int rx_cyc;
    rx_cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cyc++;
      if (rx_cyc >= HOLD_AT && rx_cyc < HOLD_AT + HOLD_LEN)
        m_tready <= 1'b0;
      else if (rx_cyc >= BUSY_AT && rx_cyc < BUSY_AT + BUSY_LEN)
        m_tready <= 1'b1;
      else
        m_tready <= ($urandom_range(99) >= 16);
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles with %0d words sent.", LIMIT, words_sent);
    $display("halfband_iq_decimate_by_two verification failed");
    $finish;
  end

endmodule
